>>> src/full_convolution_fir_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the full convolution FIR unit
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef FULL_CONVOLUTION_FIR_UNIT_MACROS_SVH
`define FULL_CONVOLUTION_FIR_UNIT_MACROS_SVH

// Assertion that is switched off while rst is high
`define FCF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also watches the reset cycles
`define FCF_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fcf_pkg.sv
// ----------------------------------------------------------------------------
// Full convolution FIR package
// Field widths, codes and the command type passed from front to back.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int VALUE_W     = 16;
  localparam int INDEX_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int RESULT_W    = 36;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 40;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 4;

  // Item kinds on s_tuser
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Register index as decoded from paddr[2]
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic signed [RESULT_W-1:0] result_t;

  // Classified item waiting for the back end
  typedef struct packed {
    logic                 is_sample;
    logic [INDEX_W-1:0]   idx;
    value_t               value;
    logic                 last;
  } cmd_t;

endpackage

>>> src/fcf_front.sv
// ----------------------------------------------------------------------------
// Full convolution FIR front end
// Accepts input items, drops out-of-range tap loads, queues the rest.
// ----------------------------------------------------------------------------
module fcf_front import fcf_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [INDEX_W-1:0] in_idx,
  input  value_t             in_value,
  input  logic               in_last,
  output logic               q_valid,
  output cmd_t               q_item,
  input  logic               q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             keep;
  logic             push;
  cmd_t             item_in;

  // Classify: samples always go through, loads only to an existing tap
  always_comb begin
    keep              = (in_mode == MODE_SAMPLE) ||
                        ((in_mode == MODE_LOAD) && (int'(in_idx) < TAPS));
    item_in.is_sample = (in_mode == MODE_SAMPLE);
    item_in.idx       = in_idx;
    item_in.value     = in_value;
    item_in.last      = in_last;
  end

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (q_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !q_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item_in;
  end

endmodule

>>> src/fcf_back.sv
// ----------------------------------------------------------------------------
// Full convolution FIR back end
// Executes queued items: tap loads, sample steps and zero-input flush steps,
// through a multiply stage, a partial-sum stage and the output register.
// ----------------------------------------------------------------------------
module fcf_back import fcf_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(TAPS + 1)-1:0]    n_eff,
  input  logic                           q_valid,
  input  cmd_t                           q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output result_t                        out_result,
  output logic                           out_end
);

  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int NG    = (TAPS + 3) / 4;
  localparam int HN    = (TAPS > 1) ? TAPS - 1 : 1;

  value_t                    coef [TAPS];
  value_t                    hist [HN];
  value_t                    win  [TAPS];
  logic signed [PROD_W-1:0]  prod_next [TAPS];
  logic signed [PROD_W-1:0]  s1_prod [TAPS];
  result_t                   part_next [NG];
  result_t                   s2_part [NG];
  result_t                   sum_next;
  logic                      flushing;
  logic [CNT_W-1:0]          flush_cnt;
  logic                      adv;
  logic                      take;
  logic                      step;
  logic                      done;
  logic                      start_flush;
  value_t                    x;
  logic                      s1_vld;
  logic                      s1_end;
  logic                      s2_vld;
  logic                      s2_end;

  // Issue control: the whole pipe moves when the output register is free
  always_comb begin
    adv         = !out_valid || out_ready;
    take        = adv && q_valid && !flushing;
    step        = (take && q_item.is_sample) || (adv && flushing);
    x           = flushing ? '0 : q_item.value;
    done        = flushing ? (flush_cnt == CNT_W'(1))
                           : (q_item.last && (n_eff == CNT_W'(1)));
    start_flush = take && q_item.is_sample && q_item.last && (n_eff != CNT_W'(1));
  end

  assign q_pop = take;

  // Window seen by the taps: new sample then the delay line
  always_comb begin
    win[0] = x;
    for (int r = 1; r < TAPS; r++) begin
      win[r] = hist[r-1];
    end
    for (int r = 0; r < TAPS; r++) begin
      prod_next[r] = coef[r] * win[r];
    end
  end

  // Partial sums over groups of four products
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < TAPS) begin
          part_next[g] = part_next[g] + RESULT_W'(s1_prod[4*g+k]);
        end
      end
    end
  end

  // Final sum, wrapping to the result width
  always_comb begin
    sum_next = '0;
    for (int g = 0; g < NG; g++) begin
      sum_next = sum_next + s2_part[g];
    end
  end

  // Control state, taps and delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_cnt <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      out_valid <= 1'b0;
      for (int r = 0; r < TAPS; r++) coef[r] <= '0;
      for (int i = 0; i < HN; i++) hist[i] <= '0;
    end else begin
      // Count down the zero-input steps after the last sample
      if (start_flush) begin
        flushing  <= 1'b1;
        flush_cnt <= n_eff - CNT_W'(1);
      end else if (adv && flushing) begin
        flush_cnt <= flush_cnt - CNT_W'(1);
        if (flush_cnt == CNT_W'(1)) flushing <= 1'b0;
      end
      // Load one tap
      if (take && !q_item.is_sample) begin
        for (int r = 0; r < TAPS; r++) begin
          if (int'(q_item.idx) == r) coef[r] <= q_item.value;
        end
      end
      // Shift the delay line, or clear it after the final output
      if (step) begin
        if (done) begin
          for (int i = 0; i < HN; i++) hist[i] <= '0;
        end else begin
          hist[0] <= x;
          for (int i = 1; i < HN; i++) hist[i] <= hist[i-1];
        end
      end
      if (adv) begin
        s1_vld    <= step;
        s2_vld    <= s1_vld;
        out_valid <= s2_vld;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_end <= step && done;
      for (int r = 0; r < TAPS; r++) begin
        s1_prod[r] <= (r < int'(n_eff)) ? prod_next[r] : '0;
      end
      s2_end     <= s1_end;
      s2_part    <= part_next;
      out_end    <= s2_end;
      out_result <= sum_next;
    end
  end

endmodule

>>> src/full_convolution_fir_unit.sv
// Full convolution FIR unit: streams the full linear convolution of a signal
// with a kernel of up to TAPS taps, giving m+n-1 outputs for m samples.
// Input stream (s_*): s_tuser 0 loads kernel tap s_tdata[3:0] with
// s_tdata[19:4]; s_tuser 1 is a sample s_tdata[19:4], s_tlast on the final
// sample of a signal. Output stream (m_*): one 36-bit exact sum per sample,
// then n-1 flush outputs after the last sample, n being tap_count clamped
// to 1..TAPS; m_tlast marks the final one. The user must set tap_count over
// the APB port only while the unit is idle; the unit does not enforce this.
// Throughput: one item per cycle while s_tready is high. A last sample holds
// the back end for itself plus the flush steps, during which the four-entry
// queue can fill and s_tready then drops. Path: an accepted sample goes
// through the queue, multiply stage, partial-sum stage and output register.
// Reset: taps and delay line clear to zero, tap_count to 1, queue empties.
// Stall: a low m_tready with m_tvalid high holds the output register and the
// back end; the front keeps taking items until its queue is full.
// ----------------------------------------------------------------------------
// Full convolution FIR unit, top level
// Stream ports, APB tap_count register, front and back ends.
// ----------------------------------------------------------------------------
module full_convolution_fir_unit import fcf_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // tap_index[3:0], value[19:4], zero pad
  input  logic                 s_tuser,   // mode
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // result[35:0], zero pad
  output logic                 m_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int CNT_W = $clog2(TAPS + 1);

  logic [COUNT_W-1:0] tap_count;
  logic [CNT_W-1:0]   n_eff;
  logic               cfg_we;
  logic               q_valid;
  logic               q_pop;
  cmd_t               q_item;
  result_t            out_result;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT);

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      tap_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Register read
  assign prdata = (paddr[2] == REG_TAP_COUNT) ? PDATA_W'(tap_count) : '0;

  // Clamp the tap count to the range the datapath holds
  always_comb begin
    if (tap_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(tap_count) > TAPS) begin
      n_eff = CNT_W'(TAPS);
    end else begin
      n_eff = CNT_W'(tap_count);
    end
  end

  fcf_front #(.TAPS(TAPS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (s_tuser),
    .in_idx   (s_tdata[INDEX_W-1:0]),
    .in_value (s_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .in_last  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  fcf_back #(.TAPS(TAPS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result),
    .out_end    (m_tlast)
  );

  assign m_tdata = M_TDATA_W'($unsigned(out_result));

endmodule

>>> src/fcf_checker.sv
// ----------------------------------------------------------------------------
// Full convolution FIR port checker
// Watches the top level's ports for output hold, reset and register behaviour.
// ----------------------------------------------------------------------------
`include "full_convolution_fir_unit_macros.svh"

module fcf_checker import fcf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [PADDR_W-1:0]   paddr,
  input logic [PDATA_W-1:0]   pwdata,
  input logic [PDATA_W-1:0]   prdata,
  input logic                 pready
);

  // Stalled output item holds
  `FCF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output item changed")

  // Reset empties the output register
  `FCF_ASSERT_RST(a_rst_idle, rst |=> !m_tvalid, "output valid after reset")

  // Reset value of tap_count reads back as one
  `FCF_ASSERT_RST(a_rst_count, rst |=> (paddr[2] != REG_TAP_COUNT) || (prdata == 32'd1), "tap_count not one after reset")

  // A written tap_count reads back
  `FCF_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT) |=> (paddr[2] != REG_TAP_COUNT) || ((prdata[4:0] == $past(pwdata[4:0])) && (prdata[31:5] == 27'd0)), "tap_count readback mismatch")

endmodule

bind full_convolution_fir_unit fcf_checker u_fcf_checker (.*);

>>> tb/sv/full_convolution_fir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Full convolution FIR checker
// Watches the sample, output and APB channels of the unit. It keeps its own
// copy of the taps, the delay line and tap_count, works out the expected
// outputs for every accepted item and compares each accepted output with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module full_convolution_fir_checker import fcf_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // tap_index[3:0], value[19:4], zero pad
  input  logic                 s_tuser,   // mode
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // result[35:0], zero pad
  input  logic                 m_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  input  logic                 pready,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    result_t sum;
    logic    closing;
  } conv_output_t;

  value_t             coeffs [TAPS];
  value_t             delay_line [TAPS-1];
  logic [COUNT_W-1:0] tap_setting;
  conv_output_t       owed_outputs [$];
  int                 mismatch_total = 0;
  int                 owed_count = 0;

  assign mismatches  = mismatch_total;
  assign outstanding = owed_count;

  // Clamp the register to the range of taps the unit holds
  function automatic int taps_active();
    if (tap_setting == '0) return 1;
    if (tap_setting > TAPS) return TAPS;
    return int'(tap_setting);
  endfunction

  // One output for sample x, then shift x into the delay line
  function automatic result_t convolve_step(value_t x, int n);
    result_t                   acc;
    logic signed [PROD_W-1:0]  prod;
    prod = coeffs[0] * x;
    acc  = result_t'(prod);
    for (int r = 1; r < n; r++) begin
      prod = coeffs[r] * delay_line[r-1];
      acc  = acc + result_t'(prod);
    end
    for (int r = TAPS - 2; r > 0; r--) delay_line[r] = delay_line[r-1];
    delay_line[0] = x;
    return acc;
  endfunction

  // Update the taps or queue the outputs that one accepted item owes
  task automatic predict_item(logic mode, logic [INDEX_W-1:0] idx, value_t v, logic last);
    int           n;
    conv_output_t owed;
    n = taps_active();
    if (mode == MODE_LOAD) begin
      if (idx < TAPS) coeffs[idx] = v;
    end else begin
      owed.sum     = convolve_step(v, n);
      owed.closing = last && (n == 1);
      owed_outputs.push_back(owed);
      if (last) begin
        // flush with zero input, mark the final output, then clear the line
        for (int k = 1; k < n; k++) begin
          owed.sum     = convolve_step('0, n);
          owed.closing = (k == n - 1);
          owed_outputs.push_back(owed);
        end
        foreach (delay_line[i]) delay_line[i] = '0;
      end
    end
  endtask

  task automatic report_mismatch(string what);
    if (mismatch_total < 100) $display("checker: %s at %0t", what, $realtime);
    mismatch_total++;
  endtask

  // Compare outputs first, then track register writes and new items
  always @(posedge clk) begin : watch
    conv_output_t want;
    if (rst) begin
      foreach (coeffs[i]) coeffs[i] = '0;
      foreach (delay_line[i]) delay_line[i] = '0;
      tap_setting = COUNT_W'(1);
      owed_outputs.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_outputs.size() == 0) begin
          report_mismatch($sformatf("output %0d with none owed",
                                    result_t'(m_tdata[RESULT_W-1:0])));
        end else begin
          want = owed_outputs.pop_front();
          if (m_tdata[RESULT_W-1:0] !== want.sum)
            report_mismatch($sformatf("result %0d, want %0d",
                                      result_t'(m_tdata[RESULT_W-1:0]), want.sum));
          if (m_tlast !== want.closing)
            report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.closing));
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_TAP_COUNT)
        tap_setting = pwdata[COUNT_W-1:0];
      if (s_tvalid && s_tready)
        predict_item(s_tuser, s_tdata[INDEX_W-1:0], s_tdata[INDEX_W +: VALUE_W], s_tlast);
    end
    owed_count <= owed_outputs.size();
  end

endmodule

>>> tb/sv/full_convolution_fir_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Full convolution FIR unit test
// Loads kernels, streams signals of random length and content through the
// unit under several tap counts and idling patterns, and lets the checker
// compare every output. Starts with a short directed run of edge cases.
// ----------------------------------------------------------------------------
module full_convolution_fir_unit_test;
  import fcf_pkg::*;

  localparam int SETTLE_CYCLES = 20;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // tap_index[3:0], value[19:4], zero pad
  logic                 s_tuser;   // mode
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // result[35:0], zero pad
  logic                 m_tlast;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int                   mismatches;
  int                   outstanding;
  int                   valid_idle_pct = 37;
  int                   ready_idle_pct = 61;

  full_convolution_fir_unit DUT (.*);

  full_convolution_fir_checker convolution_watch (.*);

  // Clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stall the output side at random
  always @(posedge clk) m_tready <= ($urandom_range(99) >= ready_idle_pct);

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Bias values toward the extremes
  function automatic value_t pick_value();
    case ($urandom_range(7))
      0:       return value_t'(-32768);
      1:       return value_t'(32767);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Offer one item after a random gap and hold until it is taken
  task automatic send_item(logic mode, logic [INDEX_W-1:0] idx, value_t v, logic last);
    while ($urandom_range(99) < valid_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - VALUE_W - INDEX_W){1'b0}}, v, idx};
    s_tuser  <= mode;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, wait for every owed output, then let loads clear the queue
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of tap_count: setup then access
  task automatic write_tap_count(logic [COUNT_W-1:0] n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TAP_COUNT, 2'b00};
    pwdata  <= PDATA_W'(n);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random signals with loads mixed in; close the open signal at the end
  task automatic random_signals(int item_goal);
    int   sent;
    logic open_signal;
    logic last;
    sent        = 0;
    open_signal = 1'b0;
    while (sent < item_goal || open_signal) begin
      if (sent < item_goal && $urandom_range(99) < 20) begin
        send_item(MODE_LOAD, INDEX_W'($urandom), pick_value(), 1'($urandom));
      end else begin
        last = ($urandom_range(7) == 0) || (sent >= item_goal);
        send_item(MODE_SAMPLE, INDEX_W'($urandom), pick_value(), last);
        open_signal = !last;
        // now and then, hold off until idle and pick a new tap count
        if (last && $urandom_range(4) == 0) begin
          drain_outputs();
          write_tap_count(COUNT_W'($urandom_range(31)));
        end
      end
      sent++;
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = MODE_LOAD;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Four-tap kernel at the value extremes, then a short signal
    write_tap_count(COUNT_W'(4));
    send_item(MODE_LOAD, 4'd0, value_t'(32767), 1'b0);
    send_item(MODE_LOAD, 4'd1, value_t'(-32768), 1'b0);
    send_item(MODE_LOAD, 4'd2, value_t'(1), 1'b0);
    send_item(MODE_LOAD, 4'd3, value_t'(-1), 1'b0);
    // last on a load must be ignored
    send_item(MODE_LOAD, 4'd15, value_t'(-32768), 1'b1);
    send_item(MODE_SAMPLE, 4'd0, value_t'(-32768), 1'b0);
    send_item(MODE_SAMPLE, 4'd15, value_t'(32767), 1'b0);
    send_item(MODE_SAMPLE, 4'd0, value_t'(0), 1'b0);
    send_item(MODE_SAMPLE, 4'd0, value_t'(-32768), 1'b1);

    // Single tap: the last sample's own output carries tlast
    drain_outputs();
    write_tap_count(COUNT_W'(1));
    send_item(MODE_SAMPLE, 4'd0, value_t'(12345), 1'b0);
    send_item(MODE_SAMPLE, 4'd0, value_t'(-1), 1'b1);

    // Change the tap count part way through a signal
    drain_outputs();
    write_tap_count(COUNT_W'(3));
    send_item(MODE_SAMPLE, 4'd0, value_t'(7), 1'b0);
    send_item(MODE_SAMPLE, 4'd0, value_t'(-7), 1'b0);
    drain_outputs();
    write_tap_count(COUNT_W'(16));
    send_item(MODE_SAMPLE, 4'd0, value_t'(32767), 1'b1);

    // Count above the tap range, sender 37 / receiver 61
    drain_outputs();
    write_tap_count(COUNT_W'(31));
    random_signals(90);

    // Count of zero, idling swapped
    drain_outputs();
    valid_idle_pct = 61;
    ready_idle_pct = 37;
    write_tap_count(COUNT_W'(0));
    random_signals(90);

    // No idling on either side
    drain_outputs();
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    write_tap_count(COUNT_W'($urandom_range(2, 16)));
    random_signals(90);

    drain_outputs();
    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
